// ----- rtl/core/epadu_pkg.sv -----
// Package with field constants and shared types of the Edwards point unit.
package epadu_pkg;

  localparam int unsigned FeW = 255;

  // p = 2^255 - 19: all ones above the low five bits, which hold 13.
  localparam logic [FeW-1:0] Prime = {{250{1'b1}}, 5'b01101};

  // 2d mod p for the curve constant d = -121665/121666.
  localparam logic [FeW-1:0] K2d = {3'b010,
    252'h406d9dc56dffce7198e80f2eef3d13000e0149a8283b156ebd69b9426b2f159};

  typedef enum logic [2:0] {
    OpAdd    = 3'd0,
    OpSub    = 3'd1,
    OpDbl    = 3'd2,
    OpAddPre = 3'd3,
    OpSubPre = 3'd4
  } op_e;

  // Modular add: operands are canonical, result is canonical.
  function automatic logic [FeW-1:0] fe_add(input logic [FeW-1:0] a, input logic [FeW-1:0] b);
    logic [FeW:0] s;
    logic [FeW:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = s - {1'b0, Prime};
    fe_add = t[FeW] ? s[FeW-1:0] : t[FeW-1:0];
  endfunction

  // Modular subtract: operands are canonical, result is canonical.
  function automatic logic [FeW-1:0] fe_sub(input logic [FeW-1:0] a, input logic [FeW-1:0] b);
    logic [FeW:0] d;
    d = {1'b0, a} - {1'b0, b};
    fe_sub = d[FeW] ? (d[FeW-1:0] + Prime) : d[FeW-1:0];
  endfunction

endpackage

// ----- rtl/core/epadu_mul.sv -----
// Iterative modular multiplier over GF(2^255-19), 32x32 partial products.
module epadu_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [epadu_pkg::FeW-1:0]    a_i,
  input  logic [epadu_pkg::FeW-1:0]    b_i,
  output logic                         done_o,
  output logic [epadu_pkg::FeW-1:0]    p_o
);

  // Product is accumulated one partial product per cycle: a limb of a times a limb of b,
  // shifted into a 512-bit accumulator. The tail folds three times with 2^256 = 38, which
  // brings the value below 2^256, and then reduces.
  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SMul  = 4'b0010,
    SFold = 4'b0100,
    SCan  = 4'b1000
  } st_e;

  st_e               st_q, st_d;
  logic [2:0]        i_q, j_q;
  logic [255:0]      a_q, b_q;
  logic [511:0]      acc_q;
  logic [1:0]        fold_q;
  logic [63:0]       pp;
  logic [31:0]       al, bl;
  logic [511:0]      pp_sh;
  logic [262:0]      folded;
  logic [255:0]      red;
  logic [256:0]      c1;

  assign al = a_q[{i_q, 5'd0} +: 32];
  assign bl = b_q[{j_q, 5'd0} +: 32];
  assign pp = al * bl;
  assign pp_sh = {448'd0, pp} << {i_q + 4'(j_q), 5'd0};
  assign folded = {7'd0, acc_q[255:0]} + 263'(acc_q[511:256]) * 263'd38;
  assign c1 = {1'b0, acc_q[255:0]} - {2'b0, epadu_pkg::Prime};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle: if (start_i) st_d = SMul;
      SMul:  if (i_q == 3'd7 && j_q == 3'd7) st_d = SFold;
      SFold: if (fold_q == 2'd2) st_d = SCan;
      SCan:  if (fold_q == 2'd0) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      i_q <= '0;
      j_q <= '0;
      fold_q <= '0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        SIdle: begin
          i_q <= '0;
          j_q <= '0;
          fold_q <= '0;
        end
        SMul: begin
          j_q <= j_q + 3'd1;
          if (j_q == 3'd7) i_q <= i_q + 3'd1;
        end
        SFold: fold_q <= fold_q + 2'd1;
        SCan: fold_q <= fold_q - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      SIdle: if (start_i) begin
        a_q <= {1'b0, a_i};
        b_q <= {1'b0, b_i};
        acc_q <= '0;
      end
      SMul: acc_q <= acc_q + pp_sh;
      SFold: acc_q <= {249'd0, folded};
      SCan: if (!c1[256]) acc_q <= {256'd0, c1[255:0]};
      default: ;
    endcase
  end

  assign red = acc_q[255:0];
  assign done_o = (st_q == SCan) && (fold_q == 2'd0);
  assign p_o = c1[256] ? red[254:0] : c1[254:0];

endmodule

// ----- rtl/core/edwards_point_add_double_unit.sv -----
// Top level of the extended twisted Edwards point add and double unit.
// Sequence: each accepted load stores one word; the final load starts nine modular products (seven for the
// precomputed forms) on one shared multiplier, one after another, and once they are done the sixteen
// result words leave one per ready cycle.
// Throughput: no request is taken until the last result word leaves; the multiplier rules.
// Reset clears control state and results; the operand store and working values are undefined.
module edwards_point_add_double_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [4:0]  slot_i,
  input  logic [63:0] word_i,
  input  logic        go_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_word_o,
  output logic [3:0]  out_slot_o,
  output logic        out_last_o
);

  localparam int unsigned W = epadu_pkg::FeW;

  // Sequencer states. Prep: precompute sums and differences. Mul: wait on multiplier.
  typedef enum logic [4:0] {
    SLoad = 5'b00001,
    SPrep = 5'b00010,
    SMul  = 5'b00100,
    SMix  = 5'b01000,
    SOut  = 5'b10000
  } st_e;

  st_e             st_q;
  logic [63:0]     store_q [32];
  logic [W-1:0]    tr_q [8];
  logic [W-1:0]    res_q [4];
  logic [2:0]      op_q;
  logic [3:0]      step_q;
  logic [3:0]      oidx_q;
  logic            mstart_q;
  logic            busy_q;
  logic [W-1:0]    ma_q, mb_q;
  logic            mdone;
  logic [W-1:0]    mp;
  logic [2:0]      prep_q;
  logic            accept;

  assign in_ready_o = (st_q == SLoad);
  assign accept = in_valid_i && in_ready_o;

  // Reads a coordinate (four words) and reduces it: at most two subtractions of p.
  function automatic logic [W-1:0] coord(input logic [255:0] v);
    logic [256:0] t;
    logic [255:0] x;
    x = v;
    t = {1'b0, x} - {2'b0, epadu_pkg::Prime};
    if (!t[256]) x = t[255:0];
    t = {1'b0, x} - {2'b0, epadu_pkg::Prime};
    if (!t[256]) x = t[255:0];
    coord = x[W-1:0];
  endfunction

  logic [255:0] cw [8];
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      cw[c] = {store_q[c*4+3], store_q[c*4+2], store_q[c*4+1], store_q[c*4]};
    end
  end

  epadu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart_q),
    .a_i     (ma_q),
    .b_i     (mb_q),
    .done_o  (mdone),
    .p_o     (mp)
  );

  // Working registers: 0 A, 1 B, 2 C, 3 D, 4 E/s1, 5 F/s2, 6 G/qd, 7 H/qs.
  // Product steps: 0..4 build A, B, C (possibly two products) and D, then
  // the four output products. The operands of each step depend on the opcode.
  logic [W-1:0] op_a, op_b;
  logic         need_mul;
  logic         launch;
  always_comb begin
    op_a = tr_q[4];
    op_b = tr_q[6];
    need_mul = 1'b1;
    unique case (step_q)
      4'd0: begin
        op_a = tr_q[4];
        op_b = (op_q == epadu_pkg::OpAdd || op_q == epadu_pkg::OpAddPre) ? tr_q[6] :
               (op_q == epadu_pkg::OpDbl) ? tr_q[4] : tr_q[7];
      end
      4'd1: begin
        op_a = tr_q[5];
        op_b = (op_q == epadu_pkg::OpAdd || op_q == epadu_pkg::OpAddPre) ? tr_q[7] :
               (op_q == epadu_pkg::OpDbl) ? tr_q[5] : tr_q[6];
      end
      4'd2: begin
        op_a = coord(cw[3]);
        op_b = (op_q == epadu_pkg::OpDbl) ? coord(cw[3]) :
               (op_q == epadu_pkg::OpAdd || op_q == epadu_pkg::OpSub) ? coord(cw[7]) :
               coord(cw[6]);
      end
      4'd3: begin
        op_a = tr_q[2];
        op_b = (op_q == epadu_pkg::OpSub) ? epadu_pkg::fe_sub('0, epadu_pkg::K2d) :
               epadu_pkg::K2d;
        need_mul = (op_q == epadu_pkg::OpAdd || op_q == epadu_pkg::OpSub ||
                    op_q == epadu_pkg::OpDbl);
      end
      4'd4: begin
        op_a = coord(cw[2]);
        op_b = (op_q == epadu_pkg::OpDbl) ? coord(cw[2]) : coord(cw[6]);
        need_mul = (op_q == epadu_pkg::OpAdd || op_q == epadu_pkg::OpSub ||
                    op_q == epadu_pkg::OpDbl);
      end
      4'd5: begin op_a = tr_q[4]; op_b = tr_q[5]; end
      4'd6: begin op_a = tr_q[6]; op_b = tr_q[7]; end
      4'd7: begin op_a = tr_q[5]; op_b = tr_q[6]; end
      4'd8: begin op_a = tr_q[4]; op_b = tr_q[7]; end
      default: need_mul = 1'b0;
    endcase
  end

  // A product is started when the sequencer needs one and the multiplier is free.
  assign launch = (st_q == SMul) && need_mul && !mstart_q && !busy_q;

  always_ff @(posedge clk_i) begin
    if (accept) store_q[slot_i] <= word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SLoad;
      step_q <= '0;
      oidx_q <= '0;
      mstart_q <= 1'b0;
      busy_q <= 1'b0;
      prep_q <= '0;
      op_q <= '0;
      for (int r = 0; r < 4; r++) res_q[r] <= '0;
    end else begin
      mstart_q <= launch;
      unique case (st_q)
        SLoad: if (accept && go_i && opcode_i <= 3'(epadu_pkg::OpSubPre)) begin
          op_q <= opcode_i;
          prep_q <= '0;
          st_q <= SPrep;
        end
        SPrep: begin
          // One add or subtract per cycle: s1, s2, then Q's difference and sum for full points.
          prep_q <= prep_q + 3'd1;
          unique case (prep_q)
            3'd0: tr_q[4] <= epadu_pkg::fe_sub(coord(cw[1]), coord(cw[0]));
            3'd1: tr_q[5] <= epadu_pkg::fe_add(coord(cw[1]), coord(cw[0]));
            3'd2: tr_q[6] <= (op_q == epadu_pkg::OpAddPre || op_q == epadu_pkg::OpSubPre) ?
                             coord(cw[4]) : epadu_pkg::fe_sub(coord(cw[5]), coord(cw[4]));
            3'd3: begin
              tr_q[7] <= (op_q == epadu_pkg::OpAddPre || op_q == epadu_pkg::OpSubPre) ?
                         coord(cw[5]) : epadu_pkg::fe_add(coord(cw[5]), coord(cw[4]));
              step_q <= '0;
              st_q <= SMul;
            end
            default: ;
          endcase
        end
        SMul: begin
          if (!need_mul) begin
            // Precomputed forms: C = Pt*2dT (already), D = 2*Pz.
            if (step_q == 4'd4) begin
              tr_q[3] <= epadu_pkg::fe_add(coord(cw[2]), coord(cw[2]));
              if (op_q == epadu_pkg::OpSubPre) tr_q[2] <= epadu_pkg::fe_sub('0, tr_q[2]);
              st_q <= SMix;
            end
            step_q <= step_q + 4'd1;
          end else if (launch) begin
            ma_q <= op_a;
            mb_q <= op_b;
            busy_q <= 1'b1;
          end else if (mdone) begin
            busy_q <= 1'b0;
            step_q <= step_q + 4'd1;
            unique case (step_q)
              4'd0: tr_q[0] <= mp;
              4'd1: tr_q[1] <= mp;
              4'd2: tr_q[2] <= mp;
              4'd3: tr_q[2] <= mp;
              4'd4: begin
                tr_q[3] <= epadu_pkg::fe_add(mp, mp);
                st_q <= SMix;
              end
              4'd5: res_q[0] <= mp;
              4'd6: res_q[1] <= mp;
              4'd7: res_q[2] <= mp;
              4'd8: begin
                res_q[3] <= mp;
                oidx_q <= '0;
                st_q <= SOut;
              end
              default: ;
            endcase
          end
        end
        SMix: begin
          tr_q[4] <= epadu_pkg::fe_sub(tr_q[1], tr_q[0]);
          tr_q[5] <= epadu_pkg::fe_sub(tr_q[3], tr_q[2]);
          tr_q[6] <= epadu_pkg::fe_add(tr_q[3], tr_q[2]);
          tr_q[7] <= epadu_pkg::fe_add(tr_q[1], tr_q[0]);
          st_q <= SMul;
        end
        SOut: if (out_ready_i) begin
          oidx_q <= oidx_q + 4'd1;
          if (oidx_q == 4'd15) st_q <= SLoad;
        end
        default: st_q <= SLoad;
      endcase
    end
  end

  logic [255:0] oc;
  assign oc = {1'b0, res_q[oidx_q[3:2]]};
  assign out_valid_o = (st_q == SOut);
  assign out_word_o = oc[{oidx_q[1:0], 6'd0} +: 64];
  assign out_slot_o = oidx_q;
  assign out_last_o = (oidx_q == 4'd15);

endmodule
